### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i; SLED_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i outside reset.
`define SLED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define SLED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/sled_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg
// Types and fixed constants shared by the status LED driver.
// ----------------------------------------------------------------------------
package sled_pkg;

  localparam int unsigned MS_W         = 11;
  localparam int unsigned DUTY_FIELD_W = 13;
  localparam int unsigned WIDE_W       = 17;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [MS_W-1:0]         FAST_ON_MS  = 11'd100;
  localparam logic [MS_W-1:0]         PULSE_MS    = 11'd150;
  localparam logic [MS_W-1:0]         GAP_MS      = 11'd1500;
  localparam logic [MS_W-1:0]         FADE_MS_RST = 11'd1000;
  localparam logic [DUTY_FIELD_W-1:0] MAX_DUTY_RST = 13'd8191;
  localparam logic [2:0]              CODE_MAX    = 3'd5;

  typedef enum logic [1:0] {
    MODE_STEADY  = 2'd0,
    MODE_BREATHE = 2'd1,
    MODE_BLINK   = 2'd2
  } led_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_MODE   = 3'd0,
    REG_CODE_COUNT = 3'd1,
    REG_INVERT     = 3'd2,
    REG_MAX_DUTY   = 3'd3,
    REG_FADE_MS    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BLINK_ON  = 2'd0,
    BLINK_OFF = 2'd1,
    BLINK_GAP = 2'd2
  } blink_phase_e;

  // Control handed to the ramp and blink sequencers: advance per transaction, restart per configuration write.
  typedef struct packed {
    logic advance;
    logic restart;
  } sled_ctrl_t;

endpackage
`default_nettype wire

### src/sled_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_in_if
// Input channel: one PWM step per transaction with its millisecond flag.
// ----------------------------------------------------------------------------
interface sled_in_if;
  logic valid;
  logic ready;
  logic ms_tick;

  modport source (output valid, output ms_tick, input ready);
  modport sink   (input valid, input ms_tick, output ready);
endinterface
`default_nettype wire

### src/sled_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_out_if
// Result channel: pin level, logical state and breathing duty.
// ----------------------------------------------------------------------------
interface sled_out_if;
  logic                               valid;
  logic                               ready;
  logic                               pin_level;
  logic                               lit;
  logic [sled_pkg::DUTY_FIELD_W-1:0]  current_duty;

  modport source (output valid, output pin_level, output lit, output current_duty,
                  input ready);
  modport sink   (input valid, input pin_level, input lit, input current_duty,
                  output ready);
endinterface
`default_nettype wire

### src/sled_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sled_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sled_pkg::CFG_IDX_W-1:0]   index;
  logic [sled_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/sled_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_div
// Restoring divider, one quotient bit per cycle: peak duty over fade time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sled_div #(
  parameter int unsigned DUTY_BITS = 13
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [DUTY_BITS-1:0]        dividend_i,
  input  wire logic [sled_pkg::MS_W-1:0]   divisor_i,
  output logic                             busy_o,
  output logic [DUTY_BITS-1:0]             quot_o,
  output logic [sled_pkg::MS_W-1:0]        rem_o
);
  import sled_pkg::*;

  localparam int unsigned CNT_W = $clog2(DUTY_BITS + 1);
  localparam logic [WIDE_W-1:0] MASK_W = WIDE_W'((1 << DUTY_BITS) - 1);
  localparam logic [WIDE_W-1:0] RST_PEAK =
      (WIDE_W'(MAX_DUTY_RST) > MASK_W) ? MASK_W : WIDE_W'(MAX_DUTY_RST);
  localparam logic [WIDE_W-1:0] RST_Q = RST_PEAK / WIDE_W'(FADE_MS_RST);
  localparam logic [WIDE_W-1:0] RST_R = RST_PEAK % WIDE_W'(FADE_MS_RST);

  logic [DUTY_BITS-1:0] work_q, work_d;
  logic [MS_W-1:0]      rem_q, rem_d;
  logic [MS_W-1:0]      div_q, div_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [MS_W:0]        trial;
  logic                 fits;

  assign trial = {rem_q, work_q[DUTY_BITS-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(DUTY_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = {work_q[DUTY_BITS-2:0], fits};
      rem_d  = fits ? MS_W'(trial - {1'b0, div_q}) : trial[MS_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = cnt_q != CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= RST_Q[DUTY_BITS-1:0];
      rem_q  <= RST_R[MS_W-1:0];
      div_q  <= FADE_MS_RST;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      work_q <= work_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = work_q;
  assign rem_o  = rem_q;

  `SLED_ASSERT(a_rem_below_div, !busy_q |-> (rem_q < div_q), "remainder not below divisor")
  `SLED_ASSERT(a_busy_ends, (busy_q && cnt_q == CNT_W'(1) && !start_i) |=> !busy_q,
               "divider ran past its last step")

endmodule
`default_nettype wire

### src/sled_ramp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_ramp
// Breathing ramp: duty level, direction, error remainder and ramp timer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sled_ramp #(
  parameter int unsigned DUTY_BITS = 13
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sled_pkg::sled_ctrl_t        ctrl_i,
  input  wire logic [sled_pkg::MS_W-1:0]   fade_i,
  input  wire logic [DUTY_BITS-1:0]        peak_i,
  input  wire logic [DUTY_BITS-1:0]        quot_i,
  input  wire logic [sled_pkg::MS_W-1:0]   rem_i,
  output logic [DUTY_BITS-1:0]             duty_o
);
  import sled_pkg::*;

  localparam int unsigned SW = DUTY_BITS + 1;
  localparam logic [DUTY_BITS-1:0] DUTY_MASK = '1;

  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic                 rising_q, rising_d;
  logic [MS_W-1:0]      err_q, err_d;
  logic [MS_W-1:0]      elapsed_q, elapsed_d;

  logic [MS_W-1:0]      elapsed_nx;
  logic [MS_W:0]        sum;
  logic                 carry;
  logic [SW-1:0]        step;
  logic [SW-1:0]        up;
  logic [DUTY_BITS-1:0] up_sat;
  logic [DUTY_BITS-1:0] down_sat;

  // The per-millisecond increment peak/fade splits into the quotient, which is
  // fixed between writes, and a carry from the running remainder.
  assign elapsed_nx = elapsed_q + MS_W'(1);
  assign sum        = {1'b0, err_q} + {1'b0, rem_i};
  assign carry      = sum >= {1'b0, fade_i};
  assign step       = {1'b0, quot_i} + SW'(carry);
  assign up         = {1'b0, duty_q} + step;
  assign up_sat     = (up > {1'b0, DUTY_MASK}) ? DUTY_MASK : up[DUTY_BITS-1:0];
  assign down_sat   = (step > {1'b0, duty_q}) ? '0 : (duty_q - step[DUTY_BITS-1:0]);

  always_comb begin
    duty_d    = duty_q;
    rising_d  = rising_q;
    err_d     = err_q;
    elapsed_d = elapsed_q;
    if (ctrl_i.restart) begin
      duty_d    = '0;
      rising_d  = 1'b1;
      err_d     = '0;
      elapsed_d = '0;
    end else if (ctrl_i.advance) begin
      if (elapsed_nx >= fade_i) begin
        duty_d    = rising_q ? peak_i : '0;
        rising_d  = !rising_q;
        err_d     = '0;
        elapsed_d = '0;
      end else begin
        duty_d    = rising_q ? up_sat : down_sat;
        err_d     = carry ? MS_W'(sum - {1'b0, fade_i}) : sum[MS_W-1:0];
        elapsed_d = elapsed_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= '0;
      rising_q  <= 1'b1;
      err_q     <= '0;
      elapsed_q <= '0;
    end else begin
      duty_q    <= duty_d;
      rising_q  <= rising_d;
      err_q     <= err_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign duty_o = duty_q;

  `SLED_ASSERT(a_err_below_fade, err_q < fade_i, "ramp remainder reached the fade time")
  `SLED_ASSERT(a_duty_in_range, duty_q <= peak_i, "breathing duty above the peak")

endmodule
`default_nettype wire

### src/sled_blink.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sled_blink
// Blink code sequencer: phase, phase timer and pulse counter.
// ----------------------------------------------------------------------------
module sled_blink (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sled_pkg::sled_ctrl_t  ctrl_i,
  input  wire logic [2:0]            code_i,
  output logic                       lit_o
);
  import sled_pkg::*;

  blink_phase_e    phase_q, phase_d;
  logic [MS_W-1:0] ms_q, ms_d;
  logic [2:0]      pulse_q, pulse_d;
  logic [MS_W-1:0] len;
  logic [MS_W-1:0] ms_nx;
  logic [2:0]      pulse_nx;

  assign ms_nx    = ms_q + MS_W'(1);
  assign pulse_nx = pulse_q + 3'd1;

  always_comb begin
    unique case (phase_q)
      BLINK_ON:  len = (code_i == 3'd0) ? FAST_ON_MS : PULSE_MS;
      BLINK_OFF: len = PULSE_MS;
      BLINK_GAP: len = GAP_MS;
      default:   len = MS_W'(1);
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    ms_d    = ms_q;
    pulse_d = pulse_q;
    if (ctrl_i.restart) begin
      phase_d = BLINK_ON;
      ms_d    = '0;
      pulse_d = '0;
    end else if (ctrl_i.advance) begin
      if (ms_nx < len) begin
        ms_d = ms_nx;
      end else begin
        ms_d = '0;
        unique case (phase_q)
          BLINK_ON: begin
            phase_d = BLINK_OFF;
          end
          BLINK_OFF: begin
            // Fast blink has no pulse count; coded blinks count off phases.
            if (code_i == 3'd0) begin
              phase_d = BLINK_ON;
            end else if (pulse_nx >= code_i) begin
              pulse_d = '0;
              phase_d = BLINK_GAP;
            end else begin
              pulse_d = pulse_nx;
              phase_d = BLINK_ON;
            end
          end
          default: begin
            phase_d = BLINK_ON;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= BLINK_ON;
      ms_q    <= '0;
      pulse_q <= '0;
    end else begin
      phase_q <= phase_d;
      ms_q    <= ms_d;
      pulse_q <= pulse_d;
    end
  end

  assign lit_o = phase_q == BLINK_ON;

endmodule
`default_nettype wire

### src/status_led_mode_driver.sv
// A result is registered, valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless input is held off, the result
// register taking the next transaction in the same cycle as it hands its
// result on. After an accepted configuration write, input ready stays low
// while the pending flag and the serial divider work out the ramp step (peak
// over fade time). Reset is asynchronous; all but the result data reset at once.
`default_nettype none
// ----------------------------------------------------------------------------
// status_led_mode_driver
// Status LED driver with steady, breathing and blink code modes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module status_led_mode_driver #(
  parameter int unsigned DUTY_BITS = 13
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sled_in_if.sink    in_i,
  sled_out_if.source out_o,
  sled_cfg_if.sink   cfg_i
);
  import sled_pkg::*;

  localparam logic [DUTY_BITS-1:0] DUTY_MASK = '1;

  // Configuration registers.
  led_mode_e                 led_mode_q;
  logic [2:0]                code_q;
  logic                      invert_q;
  logic [DUTY_FIELD_W-1:0]   max_duty_q;
  logic [MS_W-1:0]           fade_q;

  // Control.
  logic                      cfg_acc;
  logic                      cfg_ok;
  logic                      div_pend_q;
  logic                      div_busy;
  logic                      in_acc;
  logic                      in_rdy;

  // Datapath.
  logic [DUTY_BITS-1:0]      pwm_q;
  logic [DUTY_BITS-1:0]      duty;
  logic [DUTY_BITS-1:0]      peak;
  logic [DUTY_BITS-1:0]      quot;
  logic [MS_W-1:0]           rem;
  logic [MS_W-1:0]           fade_eff;
  logic [WIDE_W-1:0]         max_duty_wide;
  logic [DUTY_BITS+DUTY_FIELD_W-1:0] duty_ext;
  logic                      blink_lit;
  logic                      lit;
  logic [DUTY_FIELD_W-1:0]   duty_field;
  sled_ctrl_t                ramp_ctrl;
  sled_ctrl_t                blink_ctrl;

  // Result register.
  logic                      out_valid_q;
  logic                      pin_q;
  logic                      lit_q;
  logic [DUTY_FIELD_W-1:0]   duty_q;

  // --------------------------------------------------------------------------
  // Configuration port. Writes are always taken; an out-of-range index, an
  // unused mode code or a pulse count above five leaves everything as it was.
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  always_comb begin
    unique case (cfg_i.index)
      REG_LED_MODE:   cfg_ok = cfg_i.data[1:0] <= 2'(MODE_BLINK);
      REG_CODE_COUNT: cfg_ok = cfg_i.data[2:0] <= CODE_MAX;
      REG_INVERT:     cfg_ok = 1'b1;
      REG_MAX_DUTY:   cfg_ok = 1'b1;
      REG_FADE_MS:    cfg_ok = 1'b1;
      default:        cfg_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_mode_q <= MODE_STEADY;
      code_q     <= '0;
      invert_q   <= 1'b0;
      max_duty_q <= MAX_DUTY_RST;
      fade_q     <= FADE_MS_RST;
    end else if (cfg_acc && cfg_ok) begin
      unique case (cfg_i.index)
        REG_LED_MODE:   led_mode_q <= led_mode_e'(cfg_i.data[1:0]);
        REG_CODE_COUNT: code_q     <= cfg_i.data[2:0];
        REG_INVERT:     invert_q   <= cfg_i.data[0];
        REG_MAX_DUTY:   max_duty_q <= cfg_i.data[DUTY_FIELD_W-1:0];
        REG_FADE_MS:    fade_q     <= cfg_i.data[MS_W-1:0];
        default:        ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Ramp step precomputation. The divider is kicked in the cycle after a write,
  // once the new register values are in place, and input is held off until
  // both the pending flag and the divider have cleared.
  // --------------------------------------------------------------------------
  assign max_duty_wide = WIDE_W'(max_duty_q);
  assign peak = (max_duty_wide > WIDE_W'(DUTY_MASK)) ? DUTY_MASK
                                                      : max_duty_wide[DUTY_BITS-1:0];
  assign fade_eff = (fade_q == '0) ? MS_W'(1) : fade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pend_q <= 1'b0;
    end else begin
      div_pend_q <= cfg_acc && cfg_ok;
    end
  end

  sled_div #(
    .DUTY_BITS (DUTY_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_pend_q),
    .dividend_i (peak),
    .divisor_i  (fade_eff),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // --------------------------------------------------------------------------
  // Input handshake. A pending configuration write goes first, so a
  // transaction offered alongside it sees the new settings.
  // --------------------------------------------------------------------------
  assign in_rdy     = !cfg_i.valid && !div_pend_q && !div_busy &&
                      (!out_valid_q || out_o.ready);
  assign in_i.ready = in_rdy;
  assign in_acc     = in_i.valid && in_rdy;

  assign ramp_ctrl.restart  = cfg_acc && cfg_ok;
  assign ramp_ctrl.advance  = in_acc && in_i.ms_tick && (led_mode_q == MODE_BREATHE);
  assign blink_ctrl.restart = cfg_acc && cfg_ok;
  assign blink_ctrl.advance = in_acc && in_i.ms_tick && (led_mode_q == MODE_BLINK);

  sled_ramp #(
    .DUTY_BITS (DUTY_BITS)
  ) u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ramp_ctrl),
    .fade_i (fade_eff),
    .peak_i (peak),
    .quot_i (quot),
    .rem_i  (rem),
    .duty_o (duty)
  );

  sled_blink u_blink (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (blink_ctrl),
    .code_i (code_q),
    .lit_o  (blink_lit)
  );

  // The PWM counter free-runs, one step per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q <= '0;
    end else if (in_acc) begin
      pwm_q <= pwm_q + DUTY_BITS'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Result selection, taken from the state as it stands before the step.
  // --------------------------------------------------------------------------
  assign duty_ext = {{DUTY_FIELD_W{1'b0}}, duty};

  always_comb begin
    unique case (led_mode_q)
      MODE_STEADY: begin
        lit        = code_q != 3'd0;
        duty_field = '0;
      end
      MODE_BREATHE: begin
        lit        = pwm_q < duty;
        duty_field = duty_ext[DUTY_FIELD_W-1:0];
      end
      MODE_BLINK: begin
        lit        = blink_lit;
        duty_field = '0;
      end
      default: begin
        lit        = 1'b0;
        duty_field = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pin_q  <= lit ^ invert_q;
      lit_q  <= lit;
      duty_q <= duty_field;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pin_level    = pin_q;
  assign out_o.lit          = lit_q;
  assign out_o.current_duty = duty_q;

  `SLED_ASSERT(a_cfg_holds_input, (cfg_acc && cfg_ok) |=> !in_acc,
               "transaction accepted while the ramp step was being recomputed")
  `SLED_ASSERT(a_result_follows_accept, in_acc |=> out_valid_q,
               "accepted transaction left no result")

endmodule
`default_nettype wire
